[design/blr_pkg.sv]
// shared types and constants for the bresenham line rasterizer
package blr_pkg;

    localparam int COORD_BITS = 16;
    localparam int INK_BITS   = 24;
    localparam int ADDR_BITS  = 26;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_BITS   = $clog2(MAX_DIM);
    localparam int DIMREG_BITS = 13;
    localparam int STRIDE_BITS = 14;
    localparam int CUR_BITS   = COORD_BITS + 1;
    localparam int DBL_BITS   = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int RGB_BYTES  = 3;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd3;

    localparam logic [DIMREG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIMREG_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 14'd1920;
    localparam logic                   FORMAT_RESET = 1'b1;

    typedef enum logic [1:0] {
        LINE_VERT = 2'd0,
        LINE_HORZ = 2'd1,
        LINE_XMAJ = 2'd2,
        LINE_YMAJ = 2'd3
    } line_case_t;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [INK_BITS-1:0]          ink;
    } item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]         pixel_address;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [INK_BITS-1:0]          ink_out;
        logic                         write_enable;
        logic                         line_done;
    } pixel_t;

endpackage

[design/bresenham_line_rasterizer.sv]
// bresenham line rasterizer: one pixel beat per step beat
// a step beat's pixel is registered into the head entry, or into the skid entry while the head is stalled
// throughput: one item per cycle while item_stall is low; loads give no pixel beat
// a two-entry result buffer absorbs a stall; item_stall rises only when both entries hold
// the single 12x14 address multiply sits between the line state and the result register
// reset: idle (no line), registers 640 / 480 / 1920 / rgb, result buffer empty
module bresenham_line_rasterizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  blr_pkg::item_t item,
    output logic           pixel_valid,
    input  logic           pixel_stall,
    output blr_pkg::pixel_t pixel,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import blr_pkg::*;

    // configuration
    logic [DIMREG_BITS-1:0] image_width_reg, image_height_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;
    logic                   pixel_format_reg;

    // line state
    logic signed [CUR_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [CUR_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [ERR_BITS-1:0] error_term_reg, error_term_next;
    logic [DBL_BITS-1:0]        double_dx_reg, double_dx_next;
    logic [DBL_BITS-1:0]        double_dy_reg, double_dy_next;
    logic                       x_neg_reg, x_neg_next;
    logic                       y_neg_reg, y_neg_next;
    logic [CNT_BITS-1:0]        points_left_reg, points_left_next;
    line_case_t                 line_case_reg, line_case_next;
    logic [INK_BITS-1:0]        held_ink_reg, held_ink_next;

    // result buffer
    logic   out_valid_reg, skid_valid_reg;
    pixel_t out_reg, skid_reg;

    logic   cfg_write;
    logic   item_go, load_go, step_go, pop;
    pixel_t result;

    logic [DIMREG_BITS-1:0] w_eff, h_eff;
    logic signed [CUR_BITS:0] w_s, h_s;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            row_stride_reg   <= STRIDE_RESET;
            pixel_format_reg <= FORMAT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIMREG_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIMREG_BITS-1:0];
                REG_ROW_STRIDE:   row_stride_reg   <= pwdata[STRIDE_BITS-1:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {{(32-DIMREG_BITS){1'b0}}, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(32-DIMREG_BITS){1'b0}}, image_height_reg};
            REG_ROW_STRIDE:   prdata = {{(32-STRIDE_BITS){1'b0}}, row_stride_reg};
            REG_PIXEL_FORMAT: prdata = {31'd0, pixel_format_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // clip bounds, limited to the largest image
    assign w_eff = (image_width_reg > DIMREG_BITS'(MAX_DIM))
                   ? DIMREG_BITS'(MAX_DIM) : image_width_reg;
    assign h_eff = (image_height_reg > DIMREG_BITS'(MAX_DIM))
                   ? DIMREG_BITS'(MAX_DIM) : image_height_reg;
    assign w_s = $signed({{(CUR_BITS+1-DIMREG_BITS){1'b0}}, w_eff});
    assign h_s = $signed({{(CUR_BITS+1-DIMREG_BITS){1'b0}}, h_eff});

    assign item_stall = skid_valid_reg;
    assign item_go    = item_valid & ~item_stall;
    assign load_go    = item_go & (item.kind == KIND_LOAD);
    assign step_go    = item_go & (item.kind == KIND_STEP);
    assign pop        = out_valid_reg & ~pixel_stall;

    // ---------------- pixel for the current point ----------------
    logic                      in_image;
    logic [DIM_BITS-1:0]       px, py;
    logic [DIM_BITS+STRIDE_BITS-1:0] row_off;
    logic [DIM_BITS+1:0]       col_off;

    assign in_image = !cur_x_reg[CUR_BITS-1] && !cur_y_reg[CUR_BITS-1]
                 && (cur_x_reg[COORD_BITS-1:0] < {{(COORD_BITS-DIMREG_BITS){1'b0}}, w_eff})
                 && (cur_y_reg[COORD_BITS-1:0] < {{(COORD_BITS-DIMREG_BITS){1'b0}}, h_eff});
    assign px      = cur_x_reg[DIM_BITS-1:0];
    assign py      = cur_y_reg[DIM_BITS-1:0];
    assign row_off = py * row_stride_reg;
    assign col_off = pixel_format_reg ? ({1'b0, px, 1'b0} + {2'b00, px}) : {2'b00, px};

    always_comb
    begin
        result = '0;
        result.line_done = 1'b1;
        if (points_left_reg != '0)
        begin
            result.pixel_address = in_image
                ? (ADDR_BITS'(row_off) + ADDR_BITS'(col_off)) : '0;
            result.pixel_x      = cur_x_reg[COORD_BITS-1:0];
            result.pixel_y      = cur_y_reg[COORD_BITS-1:0];
            result.ink_out      = pixel_format_reg ? held_ink_reg
                                  : {{(INK_BITS-8){1'b0}}, held_ink_reg[7:0]};
            result.write_enable = in_image;
            result.line_done    = (points_left_reg == CNT_BITS'(1));
        end
    end

    // ---------------- line setup ----------------
    logic signed [CUR_BITS-1:0] x0, y0, x1, y1, dx, dy;
    logic [CUR_BITS-1:0]        adx, ady;
    logic signed [CUR_BITS:0]   lo, hi, a_clip, b_clip;
    logic                       h_empty;

    assign x0  = CUR_BITS'(item.start_x);
    assign y0  = CUR_BITS'(item.start_y);
    assign x1  = CUR_BITS'(item.end_x);
    assign y1  = CUR_BITS'(item.end_y);
    assign dx  = x1 - x0;
    assign dy  = y1 - y0;
    assign adx = dx[CUR_BITS-1] ? CUR_BITS'(-dx) : dx;
    assign ady = dy[CUR_BITS-1] ? CUR_BITS'(-dy) : dy;

    // horizontal span: order, clip to [0, w-1]
    assign lo     = (x0 < x1) ? (CUR_BITS+1)'(x0) : (CUR_BITS+1)'(x1);
    assign hi     = (x0 < x1) ? (CUR_BITS+1)'(x1) : (CUR_BITS+1)'(x0);
    assign a_clip = lo[CUR_BITS] ? '0 : lo;
    assign b_clip = (hi >= w_s) ? (w_s - (CUR_BITS+1)'(1)) : hi;
    assign h_empty = y0[CUR_BITS-1] || ((CUR_BITS+1)'(y0) >= h_s)
                  || (!lo[CUR_BITS] && lo >= w_s) || hi[CUR_BITS] || (a_clip > b_clip);

    // ---------------- next state ----------------
    logic signed [CUR_BITS-1:0] xs, ys;
    logic signed [ERR_BITS-1:0] ddx_s, ddy_s, err_adj;
    logic                       err_pos;

    assign xs      = x_neg_reg ? -(CUR_BITS'(1)) : CUR_BITS'(1);
    assign ys      = y_neg_reg ? -(CUR_BITS'(1)) : CUR_BITS'(1);
    assign ddx_s   = $signed({1'b0, double_dx_reg});
    assign ddy_s   = $signed({1'b0, double_dy_reg});
    assign err_pos = !error_term_reg[ERR_BITS-1];

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        error_term_next  = error_term_reg;
        double_dx_next   = double_dx_reg;
        double_dy_next   = double_dy_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        points_left_next = points_left_reg;
        line_case_next   = line_case_reg;
        held_ink_next    = held_ink_reg;
        err_adj          = error_term_reg;

        if (load_go)
        begin
            held_ink_next   = item.ink;
            x_neg_next      = dx[CUR_BITS-1];
            y_neg_next      = dy[CUR_BITS-1];
            double_dx_next  = {adx, 1'b0};
            double_dy_next  = {ady, 1'b0};
            cur_x_next      = x0;
            cur_y_next      = y0;
            error_term_next = '0;
            if (adx == '0)
            begin
                line_case_next   = LINE_VERT;
                points_left_next = ady;
            end
            else if (ady == '0)
            begin
                line_case_next = LINE_HORZ;
                x_neg_next     = 1'b0;
                if (h_empty)
                    points_left_next = '0;
                else
                begin
                    cur_x_next       = a_clip[CUR_BITS-1:0];
                    points_left_next = CNT_BITS'(b_clip - a_clip + (CUR_BITS+1)'(1));
                end
            end
            else if (adx > ady)
            begin
                line_case_next   = LINE_XMAJ;
                points_left_next = adx;
                error_term_next  = $signed({1'b0, ady, 1'b0}) - $signed(ERR_BITS'(adx));
            end
            else
            begin
                line_case_next   = LINE_YMAJ;
                points_left_next = ady;
                error_term_next  = $signed({1'b0, adx, 1'b0}) - $signed(ERR_BITS'(ady));
            end
        end
        else if (step_go && points_left_reg != '0)
        begin
            points_left_next = points_left_reg - CNT_BITS'(1);
            case (line_case_reg)
                LINE_VERT: cur_y_next = cur_y_reg + ys;
                LINE_HORZ: cur_x_next = cur_x_reg + CUR_BITS'(1);
                LINE_XMAJ:
                begin
                    if (err_pos)
                    begin
                        cur_y_next = cur_y_reg + ys;
                        err_adj    = error_term_reg - ddx_s;
                    end
                    error_term_next = err_adj + ddy_s;
                    cur_x_next      = cur_x_reg + xs;
                end
                LINE_YMAJ:
                begin
                    if (err_pos)
                    begin
                        cur_x_next = cur_x_reg + xs;
                        err_adj    = error_term_reg - ddy_s;
                    end
                    error_term_next = err_adj + ddx_s;
                    cur_y_next      = cur_y_reg + ys;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            error_term_reg  <= '0;
            double_dx_reg   <= '0;
            double_dy_reg   <= '0;
            x_neg_reg       <= 1'b0;
            y_neg_reg       <= 1'b0;
            points_left_reg <= '0;
            line_case_reg   <= LINE_VERT;
            held_ink_reg    <= '0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            error_term_reg  <= error_term_next;
            double_dx_reg   <= double_dx_next;
            double_dy_reg   <= double_dy_next;
            x_neg_reg       <= x_neg_next;
            y_neg_reg       <= y_neg_next;
            points_left_reg <= points_left_next;
            line_case_reg   <= line_case_next;
            held_ink_reg    <= held_ink_next;
        end
    end

    // ---------------- result buffer: head plus skid entry ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (step_go)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    // ---------------- checks ----------------
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the head is empty");

    a_step_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && points_left_reg != '0) |=>
            (points_left_reg == $past(points_left_reg) - CNT_BITS'(1)))
        else $error("step beat did not consume one point");

    a_idle_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && points_left_reg == '0) |=> (points_left_reg == '0))
        else $error("step beat while idle started a line");

    a_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && out_valid_reg && !pop) |=> (out_valid_reg && skid_valid_reg))
        else $error("result beat lost while the head was stalled");

endmodule
